>>> hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// condition never holds
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("assertion failed: forbidden condition");

`else

`define ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

>>> hw/rtl/bilhi_pkg.sv
package bilhi_pkg;

  // fixed field widths
  localparam int unsigned ID_W    = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned LIMIT_W = 9;
  localparam int unsigned COUNT_W = 9;

  // defaults
  localparam int unsigned CAPACITY_DEF    = 256;
  localparam int unsigned MODULUS_DEF     = 211;
  localparam int unsigned LIMIT_RESET_VAL = 256;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_ADD,
    ST_SCAN,
    ST_LOOK,
    ST_LOOK_WAIT,
    ST_RESP
  } state_e;

endpackage

>>> hw/rtl/bilhi_ram.sv
module bilhi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/bilhi_mod.sv
module bilhi_mod import bilhi_pkg::*; #(
  parameter int unsigned MODULUS = MODULUS_DEF,
  localparam int unsigned SW = $clog2(MODULUS)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [ID_W-1:0] value_i,
  output logic            done_o,
  output logic [SW-1:0]   rem_o
);

  // floor(2^32 / MODULUS): the quotient estimate is exact or one short
  localparam logic [2*ID_W-1:0] RECIP_WIDE = (64'd1 << ID_W) / 64'(MODULUS);
  localparam logic [ID_W-1:0]   RECIP      = RECIP_WIDE[ID_W-1:0];
  localparam logic [ID_W-1:0]   MOD_W      = ID_W'(MODULUS);

  // step codes of the sequencer
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_FIX  = 2'd1;
  localparam logic [1:0] PH_REM  = 2'd2;
  localparam logic [1:0] PH_QUOT = 2'd3;

  logic [1:0]        ph_q, ph_d;
  logic              done_q, done_d;
  logic [ID_W-1:0]   val_q, val_d;
  logic [ID_W-1:0]   acc_q, acc_d;
  logic [ID_W-1:0]   mul_a, mul_b;
  logic [2*ID_W-1:0] prod;

  // one shared multiplier for quotient estimate and remainder, then one correction
  always_comb begin
    mul_a  = (ph_q == PH_QUOT) ? val_q : acc_q;
    mul_b  = (ph_q == PH_QUOT) ? RECIP : MOD_W;
    prod   = (2*ID_W)'(mul_a) * (2*ID_W)'(mul_b);
    val_d  = val_q;
    acc_d  = acc_q;
    ph_d   = ph_q;
    done_d = 1'b0;
    if (start_i) begin
      val_d = value_i;
      ph_d  = PH_QUOT;
    end else begin
      unique case (ph_q)
        PH_QUOT: begin
          acc_d = prod[2*ID_W-1:ID_W];
          ph_d  = PH_REM;
        end
        PH_REM: begin
          // true remainder plus at most one modulus
          acc_d = val_q - prod[ID_W-1:0];
          ph_d  = PH_FIX;
        end
        PH_FIX: begin
          acc_d  = (acc_q >= MOD_W) ? (acc_q - MOD_W) : acc_q;
          ph_d   = PH_IDLE;
          done_d = 1'b1;
        end
        PH_IDLE: begin
          ph_d = PH_IDLE;
        end
      endcase
    end
  end

  // step counter and done flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign rem_o  = acc_q[SW-1:0];

endmodule

>>> hw/rtl/bounded_id_list_with_hash_index.sv
// Ordered list of up to CAPACITY 32-bit ids plus a direct-mapped record table
// of MODULUS slots (slot = id mod MODULUS). Input tuser carries the operation
// (add, remove, lookup); tdata carries id and record word. Each item gives one
// result: accepted flag in tuser, record word and list count in tdata. One
// item is worked at a time. Every item first runs the slot index through a
// modulo unit of three steps (quotient estimate, remainder, one correction)
// that reuses one 32x32 multiplier for the first two. A rejected add, a
// remove on an empty list and the unused code then go straight to the result;
// an add writes both memories in one state, a lookup reads the record table
// and waits for its registered read. A remove scans the list one entry per
// cycle through the list memory's single read port, compacting the tail in
// the same pass. The input is ready again in the cycle after the result is
// loaded, so the next item is taken while a finished result still waits in
// the output register; a second finished result waits for the output to drain.
`include "assert_macros.svh"

module bounded_id_list_with_hash_index import bilhi_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned MODULUS  = MODULUS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration: max_entries
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] cfg_data_i,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,  // [31:0] entry_id, [63:32] entry_data
  input  logic [OP_W-1:0]    s_axis_tuser,  // [1:0] operation
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [47:0]        m_axis_tdata,  // [31:0] found_data, [40:32] entry_count
  output logic               m_axis_tuser   // [0] accepted
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = $clog2(MODULUS);
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  state_e               state_q, state_d;
  op_e                  op_q;
  logic [ID_W-1:0]      id_q;
  logic [DATA_W-1:0]    data_q;
  logic [SW-1:0]        slot_q, slot_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        pend_idx_q, pend_idx_d;
  logic                 rd_pend_q, rd_pend_d;
  logic                 found_q, found_d;
  logic [LIMIT_W-1:0]   limit_q;
  logic [MODULUS-1:0]   valid_q, valid_d;
  logic                 res_acc_q, res_acc_d;
  logic [DATA_W-1:0]    res_data_q, res_data_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_acc_q;
  logic [DATA_W-1:0]    out_data_q;
  logic [COUNT_W-1:0]   out_cnt_q;
  logic                 out_load;

  logic                 s_fire;
  logic                 mod_done;
  logic [SW-1:0]        mod_rem;
  logic [LW-1:0]        count_ext;
  logic                 list_full;
  logic                 hit;

  logic                 list_we, list_re;
  logic [AW-1:0]        list_waddr, list_raddr;
  logic [ID_W-1:0]      list_wdata, list_rdata;
  logic                 slot_we, slot_re;
  logic [DATA_W-1:0]    slot_rdata;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  assign count_ext = LW'(count_q);
  assign list_full = (count_ext >= LW'(limit_q)) || (count_q == CW'(CAPACITY));

  // slot index unit
  bilhi_mod #(
    .MODULUS (MODULUS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_fire),
    .value_i (s_axis_tdata[ID_W-1:0]),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // ordered id list
  bilhi_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (list_wdata),
    .re_i    (list_re),
    .raddr_i (list_raddr),
    .rdata_o (list_rdata)
  );

  // record word per slot
  bilhi_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MODULUS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_q),
    .wdata_i (data_q),
    .re_i    (slot_re),
    .raddr_i (slot_q),
    .rdata_o (slot_rdata)
  );

  // sequencer: next state, memory controls, result
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pend_idx_d  = pend_idx_q;
    rd_pend_d   = 1'b0;
    found_d     = found_q;
    valid_d     = valid_q;
    res_acc_d   = res_acc_q;
    res_data_d  = res_data_q;
    out_load    = 1'b0;
    list_we     = 1'b0;
    list_re     = 1'b0;
    list_waddr  = count_q[AW-1:0];
    list_wdata  = id_q;
    list_raddr  = idx_q[AW-1:0];
    slot_we     = 1'b0;
    slot_re     = 1'b0;
    hit         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          slot_d     = mod_rem;
          res_acc_d  = 1'b0;
          res_data_d = '0;
          idx_d      = '0;
          found_d    = 1'b0;
          unique case (op_q)
            OP_ADD:    state_d = list_full ? ST_RESP : ST_ADD;
            OP_REMOVE: state_d = (count_q == '0) ? ST_RESP : ST_SCAN;
            OP_LOOKUP: state_d = ST_LOOK;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_ADD: begin
        list_we          = 1'b1;
        slot_we          = 1'b1;
        valid_d[slot_q]  = 1'b1;
        count_d          = count_q + CW'(1);
        res_acc_d        = 1'b1;
        state_d          = ST_RESP;
      end
      ST_SCAN: begin
        // issue the next read while the list has entries left
        if (idx_q < count_q) begin
          list_re    = 1'b1;
          idx_d      = idx_q + CW'(1);
          pend_idx_d = idx_q;
          rd_pend_d  = 1'b1;
        end
        // compare before the match, move entries down after it
        if (rd_pend_q) begin
          hit        = !found_q && (list_rdata == id_q);
          list_we    = found_q;
          list_waddr = AW'(pend_idx_q - CW'(1));
          list_wdata = list_rdata;
          found_d    = found_q || hit;
          if (pend_idx_q == count_q - CW'(1)) begin
            if (found_d) begin
              count_d         = count_q - CW'(1);
              valid_d[slot_q] = 1'b0;
            end
            res_acc_d = found_d;
            state_d   = ST_RESP;
          end
        end
      end
      ST_LOOK: begin
        slot_re = 1'b1;
        state_d = ST_LOOK_WAIT;
      end
      ST_LOOK_WAIT: begin
        res_acc_d  = valid_q[slot_q];
        res_data_d = valid_q[slot_q] ? slot_rdata : '0;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = (out_valid_q && !m_axis_tready) || out_load;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      limit_q     <= LIMIT_W'(LIMIT_RESET_VAL);
      valid_q     <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      valid_q     <= valid_d;
      rd_pend_q   <= rd_pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q   <= op_e'(s_axis_tuser);
      id_q   <= s_axis_tdata[ID_W-1:0];
      data_q <= s_axis_tdata[ID_W +: DATA_W];
    end
    slot_q     <= slot_d;
    idx_q      <= idx_d;
    pend_idx_q <= pend_idx_d;
    res_acc_q  <= res_acc_d;
    res_data_q <= res_data_d;
    if (out_load) begin
      out_acc_q  <= res_acc_q;
      out_data_q <= res_data_q;
      out_cnt_q  <= count_ext[COUNT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_acc_q;
  assign m_axis_tdata  = {7'd0, out_cnt_q, out_data_q};

  // checks
  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CW'(CAPACITY))
  `ASSERT_IMPL(a_mod_done_in_mod, clk_i, rst_ni, mod_done, state_q == ST_MOD)
  `ASSERT_IMPL(a_shift_after_match, clk_i, rst_ni, list_we && state_q == ST_SCAN, found_q)
  `ASSERT_IMPL(a_count_moves, clk_i, rst_ni, count_q != $past(count_q), $past(state_q) == ST_ADD || $past(state_q) == ST_SCAN)

endmodule
